### rtl/hsc_pkg.sv
// Shared types, codes and bit-layout functions for the SECDED codec.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package hsc_pkg;

    localparam int CW_BITS  = 64;
    localparam int SYN_BITS = 6;
    localparam int R_BITS   = 3;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAN     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_DOUBLE    = 2'd2
    } t_status;

    // Control that travels beside the payload from stage to stage.
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [R_BITS-1:0] r;
    } t_ctl;

    // Data bit d (counted from 0) lands on the (d+1)-th position (1-based) that is not a power of two.
    function automatic logic [CW_BITS-1:0] scatter_data(input logic [CW_BITS-1:0] data);
        logic [CW_BITS-1:0] cw;
        int                 d;
        cw = '0;
        d  = 0;
        for (int p = 1; p < CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                cw[p-1] = data[d];
                d++;
            end
        end
        return cw;
    endfunction

    // Inverse of scatter_data: pack the data positions from bit 0 upward.
    function automatic logic [CW_BITS-1:0] gather_data(input logic [CW_BITS-1:0] cw);
        logic [CW_BITS-1:0] data;
        int                 d;
        data = '0;
        d    = 0;
        for (int p = 1; p < CW_BITS; p++) begin
            if ((p & (p - 1)) != 0) begin
                data[d] = cw[p-1];
                d++;
            end
        end
        return data;
    endfunction

    // Bit b is set when position b+1 is covered by parity bit i.
    function automatic logic [CW_BITS-1:0] cover_mask(input int i);
        logic [CW_BITS-1:0] m;
        m = '0;
        for (int b = 0; b < CW_BITS - 1; b++) begin
            m[b] = (((b + 1) >> i) & 1) != 0;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/hsc_prep.sv
// First pipeline stage: clamps the parity count, lays data onto codeword positions
// (encode) or takes the received codeword (decode), and trims to the code length.
// Depends on hsc_pkg.
`default_nettype none

module hsc_prep #(
    parameter int MAX_PARITY_BITS = 6
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_kind,
    input  wire logic [hsc_pkg::R_BITS-1:0]   i_parity_count,
    input  wire logic [hsc_pkg::CW_BITS-1:0]  i_data_word,
    output hsc_pkg::t_ctl                     o_ctl,
    output logic      [hsc_pkg::CW_BITS-1:0]  o_word,
    output logic                              o_top
);
    import hsc_pkg::*;

    localparam logic [R_BITS-1:0] R_MIN = R_BITS'(2);
    localparam logic [R_BITS-1:0] R_MAX = R_BITS'(MAX_PARITY_BITS);

    logic [R_BITS-1:0]  r_clamped;
    logic [6:0]         hamming_len;
    logic [CW_BITS-1:0] len_mask;
    logic [CW_BITS-1:0] placed;

    t_ctl               r_ctl, n_ctl;
    logic [CW_BITS-1:0] r_word, n_word;
    logic               r_top, n_top;

    always_comb begin
        if (i_parity_count < R_MIN) begin
            r_clamped = R_MIN;
        end else if (i_parity_count > R_MAX) begin
            r_clamped = R_MAX;
        end else begin
            r_clamped = i_parity_count;
        end
        // Positions 1 .. 2^r-1 carry the Hamming code; the overall bit is kept aside.
        hamming_len = (7'd1 << r_clamped) - 7'd1;
        len_mask    = ~({CW_BITS{1'b1}} << hamming_len);
        placed      = (i_kind == KIND_ENCODE) ? scatter_data(i_data_word) : i_data_word;

        n_ctl.valid = i_valid;
        n_ctl.kind  = i_kind;
        n_ctl.r     = r_clamped;
        n_word      = placed & len_mask;
        n_top       = (i_kind == KIND_DECODE) ? i_data_word[hamming_len[5:0]] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_top  <= n_top;
    end

    assign o_ctl  = r_ctl;
    assign o_word = r_word;
    assign o_top  = r_top;

endmodule

`default_nettype wire

### rtl/hsc_parity.sv
// Second pipeline stage: the six Hamming parity trees and the parity of the
// whole Hamming part of the word. Depends on hsc_pkg.
`default_nettype none

module hsc_parity (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hsc_pkg::t_ctl                 i_ctl,
    input  wire logic [hsc_pkg::CW_BITS-1:0]   i_word,
    input  wire logic                          i_top,
    output hsc_pkg::t_ctl                      o_ctl,
    output logic      [hsc_pkg::CW_BITS-1:0]   o_word,
    output logic                               o_top,
    output logic      [hsc_pkg::SYN_BITS-1:0]  o_par,
    output logic                               o_xsum
);
    import hsc_pkg::*;

    t_ctl                r_ctl;
    logic [CW_BITS-1:0]  r_word;
    logic                r_top;
    logic [SYN_BITS-1:0] r_par, n_par;
    logic                r_xsum, n_xsum;

    always_comb begin
        for (int i = 0; i < SYN_BITS; i++) begin
            n_par[i] = ^(i_word & cover_mask(i));
        end
        n_xsum = ^i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= i_word;
        r_top  <= i_top;
        r_par  <= n_par;
        r_xsum <= n_xsum;
    end

    assign o_ctl  = r_ctl;
    assign o_word = r_word;
    assign o_top  = r_top;
    assign o_par  = r_par;
    assign o_xsum = r_xsum;

endmodule

`default_nettype wire

### rtl/hsc_finish.sv
// Third pipeline stage: inserts parity bits and the overall bit (encode), or
// classifies, corrects and repacks the data (decode). Holds the output register.
// Depends on hsc_pkg.
`default_nettype none

module hsc_finish (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hsc_pkg::t_ctl                 i_ctl,
    input  wire logic [hsc_pkg::CW_BITS-1:0]   i_word,
    input  wire logic                          i_top,
    input  wire logic [hsc_pkg::SYN_BITS-1:0]  i_par,
    input  wire logic                          i_xsum,
    output logic                               o_valid,
    output logic      [hsc_pkg::CW_BITS-1:0]   o_result_word,
    output logic      [1:0]                    o_status,
    output logic      [hsc_pkg::SYN_BITS-1:0]  o_syndrome
);
    import hsc_pkg::*;

    logic [SYN_BITS-1:0] hamming_len;
    logic [SYN_BITS-1:0] par_used;
    logic                enc_overall;
    logic [CW_BITS-1:0]  enc_word;
    logic                dec_overall;
    logic [CW_BITS-1:0]  fixed_word;
    t_status             dec_status;

    logic                r_valid;
    logic [CW_BITS-1:0]  r_result, n_result;
    t_status             r_status, n_status;
    logic [SYN_BITS-1:0] r_syndrome, n_syndrome;

    always_comb begin
        hamming_len = SYN_BITS'((7'd1 << i_ctl.r) - 7'd1);

        // Encode: only parity bits below r exist; the overall bit goes on top.
        par_used    = i_par & hamming_len;
        enc_overall = i_xsum ^ (^par_used);
        enc_word    = i_word;
        for (int i = 0; i < SYN_BITS; i++) begin
            enc_word[(1 << i) - 1] = enc_word[(1 << i) - 1] | par_used[i];
        end
        enc_word[hamming_len] = enc_overall;

        // Decode: odd overall parity means one error; even with a syndrome, two.
        dec_overall = i_xsum ^ i_top;
        fixed_word  = i_word;
        if (dec_overall) begin
            dec_status = ST_CORRECTED;
            if (i_par != '0) begin
                fixed_word = i_word ^ (CW_BITS'(1) << (i_par - SYN_BITS'(1)));
            end
        end else if (i_par != '0) begin
            dec_status = ST_DOUBLE;
        end else begin
            dec_status = ST_CLEAN;
        end

        if (i_ctl.kind == KIND_ENCODE) begin
            n_result   = enc_word;
            n_status   = ST_CLEAN;
            n_syndrome = '0;
        end else begin
            n_result   = gather_data(fixed_word);
            n_status   = dec_status;
            n_syndrome = i_par;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_status   <= n_status;
        r_syndrome <= n_syndrome;
    end

    assign o_valid       = r_valid;
    assign o_result_word = r_result;
    assign o_status      = r_status;
    assign o_syndrome    = r_syndrome;

endmodule

`default_nettype wire

### rtl/hamming_secded_codec_core.sv
// Top level of the extended Hamming SECDED encoder/decoder, a three-stage pipeline.
// Depends on hsc_pkg, hsc_prep, hsc_parity and hsc_finish.
//
//   Channel   | Handshake            | Payload
//   ----------+----------------------+-----------------------------------------
//   command   | start, busy          | i_kind, i_parity_count, i_data_word
//   result    | o_result_valid       | o_result_word, o_status, o_syndrome
//
// A transfer on the command channel happens at a rising edge with start high and
// busy low. Busy is always low, so a new command may be issued in every cycle.
// Each command yields exactly one result, which passes through the three register
// stages (prep, parity trees, finish) in order and is shown for a single cycle while
// o_result_valid is high. The receiver cannot stall, and nothing inside ever waits.
// A synchronous low reset empties the pipeline; results in flight at that time are
// dropped.
`default_nettype none

module hamming_secded_codec_core #(
    // Largest parity count accepted; larger requests are clamped to it.
    parameter int MAX_PARITY_BITS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [hsc_pkg::R_BITS-1:0]    i_parity_count,
    input  wire logic [hsc_pkg::CW_BITS-1:0]   i_data_word,
    output logic                               o_result_valid,
    output logic      [hsc_pkg::CW_BITS-1:0]   o_result_word,
    output logic      [1:0]                    o_status,
    output logic      [hsc_pkg::SYN_BITS-1:0]  o_syndrome
);
    import hsc_pkg::*;

    t_ctl                s1_ctl;
    logic [CW_BITS-1:0]  s1_word;
    logic                s1_top;

    t_ctl                s2_ctl;
    logic [CW_BITS-1:0]  s2_word;
    logic                s2_top;
    logic [SYN_BITS-1:0] s2_par;
    logic                s2_xsum;

    // Every stage advances on every clock, so the block is never busy.
    assign busy = 1'b0;

    // Stage 1: clamp r, place data bits (encode) and trim to the code length.
    // The overall parity bit of a received codeword is carried separately.
    hsc_prep #(
        .MAX_PARITY_BITS(MAX_PARITY_BITS)
    ) u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start),
        .i_kind         (i_kind),
        .i_parity_count (i_parity_count),
        .i_data_word    (i_data_word),
        .o_ctl          (s1_ctl),
        .o_word         (s1_word),
        .o_top          (s1_top)
    );

    // Stage 2: the parity trees. For encode they give the parity bits to insert;
    // for decode the same trees give the syndrome.
    hsc_parity u_parity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s1_ctl),
        .i_word  (s1_word),
        .i_top   (s1_top),
        .o_ctl   (s2_ctl),
        .o_word  (s2_word),
        .o_top   (s2_top),
        .o_par   (s2_par),
        .o_xsum  (s2_xsum)
    );

    // Stage 3: build the codeword, or correct, classify and repack the data,
    // into the output register.
    hsc_finish u_finish (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (s2_ctl),
        .i_word        (s2_word),
        .i_top         (s2_top),
        .i_par         (s2_par),
        .i_xsum        (s2_xsum),
        .o_valid       (o_result_valid),
        .o_result_word (o_result_word),
        .o_status      (o_status),
        .o_syndrome    (o_syndrome)
    );

endmodule

`default_nettype wire
